@@ rtl/cpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types, codes and constants of the carousel position controller.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int CNT_W  = 16;
  localparam int DUTY_W = 7;
  localparam int SLOT_W = 4;

  localparam logic [DUTY_W-1:0] DUTY_MAX      = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_FLOOR_FAR  = 7'd10;
  localparam logic [DUTY_W-1:0] DUTY_FLOOR_NEAR = 7'd5;
  localparam logic [CNT_W-1:0]  MIN_EDGES     = 16'd2700;
  localparam logic [CNT_W-1:0]  START_DELAY   = 16'd100;
  localparam logic [CNT_W-1:0]  DOWN_DELAY    = 16'd100;
  localparam logic [CNT_W-1:0]  SEEN_MAX      = 16'hFFFF;
  localparam logic [CNT_W:0]    TRIM_BAND     = 17'd5;
  localparam logic [3:0]        TRIM_PERIOD   = 4'd10;
  localparam logic [4:0]        BRAKE_TOGGLE  = 5'd16;
  localparam logic signed [4:0] HALF_TURN     = 5'sd7;
  localparam logic [SLOT_W-1:0] FULL_DIST     = 4'd15;

  typedef enum logic [2:0] {
    KIND_CMD   = 3'd0,
    KIND_TICK  = 3'd1,
    KIND_ENC   = 3'd2,
    KIND_INDEX = 3'd3,
    KIND_TRIM  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    LIFT_NONE = 2'd0,
    LIFT_UP   = 2'd1,
    LIFT_DOWN = 2'd2
  } lift_req_t;

  typedef enum logic [1:0] {
    ST_READY  = 2'd0,
    ST_MOVING = 2'd1,
    ST_ERROR  = 2'd2,
    ST_ABSENT = 2'd3
  } disk_status_t;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_START, SEQ_UP, SEQ_CHECK, SEQ_DSTART,
    SEQ_ROT, SEQ_DDOWN, SEQ_DOWN, SEQ_ERR
  } seq_step_t;

  typedef enum logic [2:0] {
    REG_DUTY_FAST, REG_DUTY_SLOW, REG_TIMEOUT, REG_PRESENCE,
    REG_STOP_LEFT, REG_STOP_RIGHT, REG_TARGET_FAR, REG_TARGET_NEAR
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [4:0]        target_slot;
    logic              label_valid;
    logic [SLOT_W-1:0] label_code;
    logic              lift_up;
    logic              lift_busy;
    logic              lift_fault;
  } cpc_item_t;

  typedef struct packed {
    lift_req_t         lift_request;
    logic              brake_on;
    logic              turn_left;
    logic [DUTY_W-1:0] motor_duty;
    disk_status_t      disk_status;
    logic              busy_res;
  } cpc_result_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_fast;
    logic [DUTY_W-1:0] duty_slow;
    logic [CNT_W-1:0]  timeout_ticks;
    logic [CNT_W-1:0]  presence_window;
    logic [CNT_W-1:0]  stop_offset_left;
    logic [CNT_W-1:0]  stop_offset_right;
    logic [CNT_W-1:0]  speed_target_far;
    logic [CNT_W-1:0]  speed_target_near;
  } cpc_cfg_t;

endpackage

@@ rtl/cpc_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_in_if
// Input event channel: valid/ready handshake with one event per transaction.
// ----------------------------------------------------------------------------
interface cpc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [4:0] target_slot;
  logic       label_valid;
  logic [3:0] label_code;
  logic       lift_up;
  logic       lift_busy;
  logic       lift_fault;

  modport source (output valid, kind, target_slot, label_valid, label_code,
                  lift_up, lift_busy, lift_fault, input ready);
  modport sink   (input valid, kind, target_slot, label_valid, label_code,
                  lift_up, lift_busy, lift_fault, output ready);
endinterface

@@ rtl/cpc_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_out_if
// Result channel: valid/ready handshake carrying the drive and status outputs.
// ----------------------------------------------------------------------------
interface cpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lift_request;
  logic       brake_on;
  logic       turn_left;
  logic [6:0] motor_duty;
  logic [1:0] disk_status;
  logic       busy_res;

  modport source (output valid, lift_request, brake_on, turn_left, motor_duty,
                  disk_status, busy_res, input ready);
  modport sink   (input valid, lift_request, brake_on, turn_left, motor_duty,
                  disk_status, busy_res, output ready);
endinterface

@@ rtl/cpc_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

@@ rtl/carousel_position_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carousel_position_controller
// Positions a 16-slot sample disk from command, tick and sensor events.
// ----------------------------------------------------------------------------
// Every accepted event yields exactly one result transaction. An event is
// captured in an input register, and once the result register is free or
// draining, the sequencer updates its state and loads the result register,
// and a new event can enter as the held one leaves; one event is taken per
// cycle as long as the result side keeps up. The result register decouples the
// two sides: a new event is taken while a finished result still waits. Outputs
// report the state after the event: lift_request pulses only on the tick that
// asks for lift movement, the other fields hold until changed. Configuration
// writes are accepted at any cycle and apply to events processed afterwards;
// write them while the block is idle. Duty writes keep data bits 6:0, clamped at 100.
// ----------------------------------------------------------------------------
module carousel_position_controller (
  input logic        clk,
  input logic        rst_n,
  cpc_in_if.sink     in_chan,
  cpc_out_if.source  out_chan,
  cpc_cfg_if.sink    cfg_chan
);
  import cpc_pkg::*;

  cpc_item_t   item_in, item_r;
  logic        in_vld_r;
  cpc_result_t res_nxt, res_r;
  logic        out_vld_r;
  cpc_cfg_t    cfg;
  logic        adv;

  // gather the input transaction payload
  assign item_in.kind        = in_chan.kind;
  assign item_in.target_slot = in_chan.target_slot;
  assign item_in.label_valid = in_chan.label_valid;
  assign item_in.label_code  = in_chan.label_code;
  assign item_in.lift_up     = in_chan.lift_up;
  assign item_in.lift_busy   = in_chan.lift_busy;
  assign item_in.lift_fault  = in_chan.lift_fault;

  // advance the held event when the result register is free or draining
  assign adv           = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || adv;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload register: capture on every input transaction
  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      item_r <= item_in;
    end
  end

  cpc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_chan.valid),
    .wr_addr (cfg_chan.addr),
    .wr_data (cfg_chan.data),
    .cfg     (cfg)
  );

  // state updates exactly when the event moves into the result register
  cpc_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (item_r),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // hold the result until the result transaction completes
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.lift_request = res_r.lift_request;
  assign out_chan.brake_on     = res_r.brake_on;
  assign out_chan.turn_left    = res_r.turn_left;
  assign out_chan.motor_duty   = res_r.motor_duty;
  assign out_chan.disk_status  = res_r.disk_status;
  assign out_chan.busy_res     = res_r.busy_res;

`ifndef SYNTH
  // duty never leaves the percent range, whether from config or trim
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.motor_duty <= DUTY_MAX)
    else $error("motor duty above 100 percent");

  // a lift-up request only comes from a running move
  a_up_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.lift_request == LIFT_UP) |->
      (res_r.busy_res && res_r.disk_status == ST_MOVING))
    else $error("lift up requested outside a move");

  // a lift-down request only comes while the move is still busy
  a_down_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.lift_request == LIFT_DOWN) |-> res_r.busy_res)
    else $error("lift down requested while not busy");

  // no event is dropped: a held event with a free result slot always advances
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_vld_r) |=> out_vld_r)
    else $error("held event did not reach the result register");
`endif

endmodule

@@ rtl/cpc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_cfg_regs
// Configuration register file; duty registers saturate at 100 percent.
// ----------------------------------------------------------------------------
module cpc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [2:0]         wr_addr,
  input  logic [15:0]        wr_data,
  output cpc_pkg::cpc_cfg_t  cfg
);
  import cpc_pkg::*;

  cpc_cfg_t          cfg_r;
  logic [DUTY_W-1:0] duty_wr;

  // clamp duty writes
  assign duty_wr = (wr_data[DUTY_W-1:0] > DUTY_MAX) ? DUTY_MAX : wr_data[DUTY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_fast         <= 7'd60;
      cfg_r.duty_slow         <= 7'd30;
      cfg_r.timeout_ticks     <= 16'd5000;
      cfg_r.presence_window   <= 16'd1000;
      cfg_r.stop_offset_left  <= 16'd100;
      cfg_r.stop_offset_right <= 16'd100;
      cfg_r.speed_target_far  <= 16'd200;
      cfg_r.speed_target_near <= 16'd100;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_addr))
        REG_DUTY_FAST:   cfg_r.duty_fast         <= duty_wr;
        REG_DUTY_SLOW:   cfg_r.duty_slow         <= duty_wr;
        REG_TIMEOUT:     cfg_r.timeout_ticks     <= wr_data;
        REG_PRESENCE:    cfg_r.presence_window   <= wr_data;
        REG_STOP_LEFT:   cfg_r.stop_offset_left  <= wr_data;
        REG_STOP_RIGHT:  cfg_r.stop_offset_right <= wr_data;
        REG_TARGET_FAR:  cfg_r.speed_target_far  <= wr_data;
        REG_TARGET_NEAR: cfg_r.speed_target_near <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/cpc_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_seq
// Move sequencer and motor state; one event updates the state per enable.
// ----------------------------------------------------------------------------
module cpc_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  cpc_pkg::cpc_item_t    item,
  input  cpc_pkg::cpc_cfg_t     cfg,
  output cpc_pkg::cpc_result_t  res_nxt
);
  import cpc_pkg::*;

  seq_step_t         step_r, step_nxt;
  disk_status_t      status_r, status_nxt;
  logic              busy_r, busy_nxt;
  logic              brake_r, brake_nxt;
  logic              left_r, left_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic [CNT_W-1:0]  tmo_r, tmo_nxt;
  logic [CNT_W-1:0]  dly_r, dly_nxt;
  logic [CNT_W-1:0]  edge_r, edge_nxt;
  logic [CNT_W-1:0]  prev_r, prev_nxt;
  logic [SLOT_W-1:0] goal_r, goal_nxt;
  logic [SLOT_W-1:0] dist_r, dist_nxt;
  logic              rot_r, rot_nxt;
  logic              stop_r, stop_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [3:0]        presc_r, presc_nxt;

  lift_req_t         req;
  logic [CNT_W-1:0]  tmo_mid, dly_mid;
  logic              tick_run;

  logic [SLOT_W-1:0] lbl_slot;
  logic signed [4:0] dir_diff;
  logic [SLOT_W-1:0] dir_abs;
  logic              dir_left;
  logic              brake_toggle, cmd_move, at_target, lift_ok, absent_chk;
  logic [CNT_W-1:0]  edge_inc, stop_lim, trim_diff;
  logic [CNT_W:0]    diff_ext;

  assign lbl_slot     = ~item.label_code;
  assign dir_diff     = signed'({1'b0, lbl_slot}) - signed'({1'b0, goal_r});
  assign dir_abs      = dir_diff[4] ? SLOT_W'(-dir_diff) : dir_diff[SLOT_W-1:0];
  assign dir_left     = dir_diff[4] ? (dir_diff >= -HALF_TURN) : (dir_diff > HALF_TURN);
  assign brake_toggle = !busy_r && (item.target_slot == BRAKE_TOGGLE) && item.lift_up;
  assign cmd_move     = !busy_r && !item.target_slot[4];
  assign at_target    = !item.label_valid || (lbl_slot == item.target_slot[SLOT_W-1:0]);
  assign lift_ok      = !item.lift_busy && !item.lift_fault;
  assign absent_chk   = (({1'b0, tmo_r} + {1'b0, cfg.presence_window}) <
                         {1'b0, cfg.timeout_ticks}) && (seen_r == '0);
  assign edge_inc     = edge_r + 1'b1;
  assign stop_lim     = left_r ? cfg.stop_offset_right : cfg.stop_offset_left;
  assign trim_diff    = edge_r - prev_r;
  assign diff_ext     = {1'b0, trim_diff};

  // sequence next step
  always_comb begin
    step_nxt = step_r;
    case (item.kind)
      KIND_CMD: begin
        if (cmd_move) step_nxt = at_target ? SEQ_IDLE : SEQ_START;
      end
      KIND_TICK: begin
        unique case (step_r)
          SEQ_START:  step_nxt = SEQ_UP;
          SEQ_UP: begin
            if (lift_ok) step_nxt = SEQ_CHECK;
            if (tmo_r == '0) step_nxt = SEQ_ERR;
          end
          SEQ_CHECK:  step_nxt = SEQ_DSTART;
          SEQ_DSTART: if (dly_r == '0) step_nxt = SEQ_ROT;
          SEQ_ROT: begin
            if (!rot_r) step_nxt = SEQ_DDOWN;
            if (tmo_r == '0 || absent_chk) step_nxt = SEQ_ERR;
          end
          SEQ_DDOWN:  if (dly_r == '0) step_nxt = SEQ_DOWN;
          SEQ_DOWN: begin
            if (lift_ok) step_nxt = SEQ_IDLE;
            if (tmo_r == '0) step_nxt = SEQ_ERR;
          end
          SEQ_ERR:    step_nxt = SEQ_IDLE;
          default:    step_nxt = step_r;
        endcase
      end
      default: ;
    endcase
  end

  // datapath and outputs
  always_comb begin
    status_nxt = status_r;
    busy_nxt   = busy_r;
    brake_nxt  = brake_r;
    left_nxt   = left_r;
    duty_nxt   = duty_r;
    tmo_nxt    = tmo_r;
    dly_nxt    = dly_r;
    edge_nxt   = edge_r;
    prev_nxt   = prev_r;
    goal_nxt   = goal_r;
    dist_nxt   = dist_r;
    rot_nxt    = rot_r;
    stop_nxt   = stop_r;
    seen_nxt   = seen_r;
    presc_nxt  = presc_r;
    req        = LIFT_NONE;
    tmo_mid    = tmo_r;
    dly_mid    = dly_r;
    tick_run   = 1'b0;
    case (item.kind)
      KIND_CMD: begin
        if (brake_toggle) begin
          brake_nxt = !brake_r;
          duty_nxt  = brake_r ? cfg.duty_fast : '0;
        end else if (cmd_move) begin
          if (at_target) begin
            status_nxt = ST_READY;
          end else begin
            goal_nxt = item.target_slot[SLOT_W-1:0];
            busy_nxt = 1'b1;
          end
        end
      end
      KIND_TICK: begin
        tick_run = 1'b1;
        unique case (step_r)
          SEQ_START: begin
            tmo_mid    = cfg.timeout_ticks;
            status_nxt = ST_MOVING;
            if (!item.lift_up) req = LIFT_UP;
          end
          SEQ_UP: ;
          SEQ_CHECK: begin
            // pick the shorter way round; no label means a full turn right
            dist_nxt  = item.label_valid ? dir_abs : FULL_DIST;
            left_nxt  = item.label_valid && dir_left;
            duty_nxt  = (item.label_valid && dir_abs <= 4'd1) ? cfg.duty_slow
                                                              : cfg.duty_fast;
            edge_nxt  = '0;
            prev_nxt  = '0;
            stop_nxt  = 1'b0;
            brake_nxt = 1'b0;
            dly_mid   = START_DELAY;
          end
          SEQ_DSTART: begin
            if (dly_r == '0) begin
              seen_nxt = '0;
              rot_nxt  = 1'b1;
            end
          end
          SEQ_ROT:   if (!rot_r) dly_mid = DOWN_DELAY;
          SEQ_DDOWN: if (dly_r == '0) req = LIFT_DOWN;
          SEQ_DOWN: begin
            if (lift_ok) begin
              status_nxt = ST_READY;
              busy_nxt   = 1'b0;
            end
          end
          SEQ_ERR: begin
            brake_nxt  = 1'b1;
            duty_nxt   = '0;
            status_nxt = (seen_r == '0) ? ST_ABSENT : ST_ERROR;
            busy_nxt   = 1'b0;
          end
          default: tick_run = 1'b0;
        endcase
        if (tick_run) begin
          tmo_nxt = tmo_mid - CNT_W'(tmo_mid != '0);
          dly_nxt = dly_mid - CNT_W'(dly_mid != '0);
        end
      end
      KIND_ENC: begin
        edge_nxt = edge_inc;
        if (stop_r && edge_inc > stop_lim) begin
          brake_nxt = 1'b1;
          duty_nxt  = '0;
          rot_nxt   = 1'b0;
          stop_nxt  = 1'b0;
          if (item.label_valid) goal_nxt = lbl_slot;
        end
      end
      KIND_INDEX: begin
        if (item.label_valid && edge_r > MIN_EDGES && rot_r) begin
          if (seen_r != SEEN_MAX) seen_nxt = seen_r + 1'b1;
          if (goal_r == lbl_slot) begin
            edge_nxt = '0;
            prev_nxt = '0;
            stop_nxt = 1'b1;
          end
        end
      end
      KIND_TRIM: begin
        if (duty_r != '0) begin
          if (presc_r < TRIM_PERIOD) begin
            presc_nxt = presc_r + 1'b1;
          end else begin
            prev_nxt  = edge_r;
            presc_nxt = '0;
            if (dist_r > 4'd1) begin
              if (diff_ext > {1'b0, cfg.speed_target_far} + TRIM_BAND) begin
                if (duty_r > DUTY_FLOOR_FAR) duty_nxt = duty_r - 1'b1;
              end else if (diff_ext + TRIM_BAND < {1'b0, cfg.speed_target_far}) begin
                if (duty_r < DUTY_MAX) duty_nxt = duty_r + 1'b1;
              end
            end else begin
              if (trim_diff > cfg.speed_target_near) begin
                if (duty_r > DUTY_FLOOR_NEAR) duty_nxt = duty_r - 1'b1;
              end else if (trim_diff < cfg.speed_target_near) begin
                if (duty_r < DUTY_MAX) duty_nxt = duty_r + 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= SEQ_IDLE;
      status_r <= ST_READY;
      busy_r   <= 1'b0;
      brake_r  <= 1'b0;
      left_r   <= 1'b0;
      duty_r   <= '0;
      tmo_r    <= '0;
      dly_r    <= '0;
      edge_r   <= '0;
      prev_r   <= '0;
      goal_r   <= '0;
      dist_r   <= '0;
      rot_r    <= 1'b0;
      stop_r   <= 1'b0;
      seen_r   <= '0;
      presc_r  <= '0;
    end else if (step_en) begin
      step_r   <= step_nxt;
      status_r <= status_nxt;
      busy_r   <= busy_nxt;
      brake_r  <= brake_nxt;
      left_r   <= left_nxt;
      duty_r   <= duty_nxt;
      tmo_r    <= tmo_nxt;
      dly_r    <= dly_nxt;
      edge_r   <= edge_nxt;
      prev_r   <= prev_nxt;
      goal_r   <= goal_nxt;
      dist_r   <= dist_nxt;
      rot_r    <= rot_nxt;
      stop_r   <= stop_nxt;
      seen_r   <= seen_nxt;
      presc_r  <= presc_nxt;
    end
  end

  assign res_nxt.lift_request = req;
  assign res_nxt.brake_on     = brake_nxt;
  assign res_nxt.turn_left    = left_nxt;
  assign res_nxt.motor_duty   = duty_nxt;
  assign res_nxt.disk_status  = status_nxt;
  assign res_nxt.busy_res     = busy_nxt;

endmodule

@@ tb/carousel_position_controller_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// carousel_position_controller_tb
// Self-checking bench for the carousel position controller.
// ----------------------------------------------------------------------------
// Drives command, tick, encoder, index and trim events through the input
// channel and checks every result transaction against a cycle-free model of
// the sequencer, the braking stop and the duty trim. Short directed checks
// cover the brake toggle, ignored commands, the lift timeout and the presence
// check; a move of random content then runs past the minimum edge count to
// the braking stop; a random phase mixes well-formed moves with noise under
// changing register settings. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module carousel_position_controller_tb;
  import cpc_pkg::*;

  localparam int STALL_LIMIT = 2000;   // cycles with no transaction at all
  localparam int SETTLE_CYCLES = 8;    // extra wait after the last result
  localparam int MAX_REPORTS = 50;

  logic clk = 1'b0;
  logic rst_n;

  always #1 clk = ~clk;

  cpc_in_if  in_chan ();
  cpc_out_if out_chan ();
  cpc_cfg_if cfg_chan ();

  carousel_position_controller u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // --------------------------------------------------------------------------
  // Model state: the controller as seen after every accepted event
  // --------------------------------------------------------------------------
  seq_step_t         m_step;
  disk_status_t      m_status;
  logic              m_busy;
  logic              m_brake;
  logic              m_left;
  logic [DUTY_W-1:0] m_duty;
  logic [CNT_W-1:0]  m_timeout;
  logic [CNT_W-1:0]  m_delay;
  logic [CNT_W-1:0]  m_edges;
  logic [CNT_W-1:0]  m_edges_prev;
  logic [CNT_W-1:0]  m_seen;
  logic [SLOT_W-1:0] m_goal;
  logic [SLOT_W-1:0] m_dist;
  logic [3:0]        m_prescale;
  logic              m_rot_en;
  logic              m_stop_pend;

  // Register copies as the block holds them (duties already clamped)
  logic [DUTY_W-1:0] c_duty_fast;
  logic [DUTY_W-1:0] c_duty_slow;
  logic [CNT_W-1:0]  c_timeout;
  logic [CNT_W-1:0]  c_presence;
  logic [CNT_W-1:0]  c_off_left;
  logic [CNT_W-1:0]  c_off_right;
  logic [CNT_W-1:0]  c_tgt_far;
  logic [CNT_W-1:0]  c_tgt_near;

  cpc_result_t pending_outputs[$];
  int          mismatch_count = 0;
  int          useful_items = 0;
  bit          idle_on = 1'b1;
  int          ready_hold = 0;

  // --------------------------------------------------------------------------
  // Model
  // --------------------------------------------------------------------------
  task automatic model_reset();
    c_duty_fast = 7'd60;    c_duty_slow = 7'd30;
    c_timeout   = 16'd5000; c_presence  = 16'd1000;
    c_off_left  = 16'd100;  c_off_right = 16'd100;
    c_tgt_far   = 16'd200;  c_tgt_near  = 16'd100;
    m_step = SEQ_IDLE;  m_status = ST_READY;
    m_busy = 1'b0;      m_brake = 1'b0;     m_left = 1'b0;    m_duty = '0;
    m_timeout = '0;     m_delay = '0;       m_edges = '0;     m_edges_prev = '0;
    m_seen = '0;        m_goal = '0;        m_dist = '0;      m_prescale = '0;
    m_rot_en = 1'b0;    m_stop_pend = 1'b0;
  endtask

  task automatic model_write_reg(cfg_reg_t idx, logic [15:0] data);
    logic [DUTY_W-1:0] duty;
    duty = data[DUTY_W-1:0];
    if (duty > DUTY_MAX) duty = DUTY_MAX;
    case (idx)
      REG_DUTY_FAST:   c_duty_fast = duty;
      REG_DUTY_SLOW:   c_duty_slow = duty;
      REG_TIMEOUT:     c_timeout   = data;
      REG_PRESENCE:    c_presence  = data;
      REG_STOP_LEFT:   c_off_left  = data;
      REG_STOP_RIGHT:  c_off_right = data;
      REG_TARGET_FAR:  c_tgt_far   = data;
      REG_TARGET_NEAR: c_tgt_near  = data;
      default: ;
    endcase
  endtask

  // Label codes are inverted slot numbers; the mapping is its own inverse.
  function automatic logic [SLOT_W-1:0] mirror_slot(logic [SLOT_W-1:0] x);
    return FULL_DIST - x;
  endfunction

  function automatic void begin_turn(logic go_left, logic [DUTY_W-1:0] duty);
    m_left = go_left;
    m_edges = '0;
    m_edges_prev = '0;
    m_stop_pend = 1'b0;
    m_brake = 1'b0;
    m_duty = duty;
  endfunction

  function automatic void pick_direction(cpc_item_t it);
    int   d;
    logic go_left;
    if (!it.label_valid) begin
      // no position known: spin right at the fast duty, treat as far
      m_dist = FULL_DIST;
      begin_turn(1'b0, c_duty_fast);
      return;
    end
    d = int'(mirror_slot(it.label_code)) - int'(m_goal);
    m_dist = SLOT_W'(d < 0 ? -d : d);
    if (d < 0) go_left = (d < -int'(HALF_TURN)) ? 1'b0 : 1'b1;
    else       go_left = (d >  int'(HALF_TURN)) ? 1'b1 : 1'b0;
    begin_turn(go_left, (m_dist > 1) ? c_duty_fast : c_duty_slow);
  endfunction

  function automatic void model_command(cpc_item_t it);
    if (m_busy) return;
    if (it.target_slot == BRAKE_TOGGLE && it.lift_up) begin
      if (m_brake) begin
        m_brake = 1'b0;
        m_duty = c_duty_fast;
      end else begin
        m_brake = 1'b1;
        m_duty = '0;
      end
      return;
    end
    if (it.target_slot >= BRAKE_TOGGLE) return;
    if (!it.label_valid || mirror_slot(it.label_code) == it.target_slot[SLOT_W-1:0]) begin
      m_status = ST_READY;
      m_step = SEQ_IDLE;
      return;
    end
    m_goal = it.target_slot[SLOT_W-1:0];
    m_step = SEQ_START;
    m_busy = 1'b1;
  endfunction

  function automatic lift_req_t model_tick(cpc_item_t it);
    lift_req_t   req;
    logic [16:0] window_sum;
    req = LIFT_NONE;
    case (m_step)
      SEQ_START: begin
        m_timeout = c_timeout;
        if (!it.lift_up) req = LIFT_UP;
        m_step = SEQ_UP;
        m_status = ST_MOVING;
      end
      SEQ_UP: begin
        if (!it.lift_busy && !it.lift_fault) m_step = SEQ_CHECK;
        if (m_timeout == 0) m_step = SEQ_ERR;
      end
      SEQ_CHECK: begin
        pick_direction(it);
        m_delay = START_DELAY;
        m_step = SEQ_DSTART;
      end
      SEQ_DSTART: begin
        if (m_delay == 0) begin
          m_seen = '0;
          m_rot_en = 1'b1;
          m_step = SEQ_ROT;
        end
      end
      SEQ_ROT: begin
        if (!m_rot_en) begin
          m_step = SEQ_DDOWN;
          m_delay = DOWN_DELAY;
        end
        if (m_timeout == 0) m_step = SEQ_ERR;
        window_sum = {1'b0, m_timeout} + {1'b0, c_presence};
        if (window_sum < {1'b0, c_timeout} && m_seen == 0) m_step = SEQ_ERR;
      end
      SEQ_DDOWN: begin
        if (m_delay == 0) begin
          req = LIFT_DOWN;
          m_step = SEQ_DOWN;
        end
      end
      SEQ_DOWN: begin
        if (!it.lift_busy && !it.lift_fault) begin
          m_status = ST_READY;
          m_step = SEQ_IDLE;
          m_busy = 1'b0;
        end
        if (m_timeout == 0) m_step = SEQ_ERR;
      end
      SEQ_ERR: begin
        m_brake = 1'b1;
        m_duty = '0;
        m_status = (m_seen == 0) ? ST_ABSENT : ST_ERROR;
        m_step = SEQ_IDLE;
        m_busy = 1'b0;
      end
      default: return LIFT_NONE;  // idle: counters hold
    endcase
    if (m_timeout != 0) m_timeout--;
    if (m_delay != 0) m_delay--;
    return req;
  endfunction

  function automatic void model_encoder(cpc_item_t it);
    logic [CNT_W-1:0] lim;
    m_edges++;
    if (!m_stop_pend) return;
    // a left turn stops on the right-hand offset and vice versa
    lim = m_left ? c_off_right : c_off_left;
    if (m_edges > lim) begin
      m_brake = 1'b1;
      m_duty = '0;
      m_rot_en = 1'b0;
      m_stop_pend = 1'b0;
      if (it.label_valid) m_goal = mirror_slot(it.label_code);
    end
  endfunction

  function automatic void model_index(cpc_item_t it);
    if (!it.label_valid) return;
    if (m_edges > MIN_EDGES && m_rot_en) begin
      if (m_seen < SEEN_MAX) m_seen++;
      if (m_goal == mirror_slot(it.label_code)) begin
        m_edges = '0;
        m_edges_prev = '0;
        m_stop_pend = 1'b1;
      end
    end
  endfunction

  function automatic void model_trim();
    logic [CNT_W-1:0] diff;
    int               tgt;
    if (m_duty == 0) return;
    if (m_prescale < TRIM_PERIOD) begin
      m_prescale++;
      return;
    end
    diff = m_edges - m_edges_prev;
    m_edges_prev = m_edges;
    if (m_dist > 1) begin
      tgt = int'(c_tgt_far);
      if (int'(diff) > tgt + int'(TRIM_BAND) && m_duty > DUTY_FLOOR_FAR) m_duty--;
      if (int'(diff) < tgt - int'(TRIM_BAND) && m_duty < DUTY_MAX) m_duty++;
    end else begin
      tgt = int'(c_tgt_near);
      if (int'(diff) > tgt && m_duty > DUTY_FLOOR_NEAR) m_duty--;
      if (int'(diff) < tgt && m_duty < DUTY_MAX) m_duty++;
    end
    m_prescale = '0;
  endfunction

  // Advance the model by one event and return the outputs it should show.
  function automatic cpc_result_t carousel_step(cpc_item_t it);
    cpc_result_t res;
    lift_req_t   req;
    req = LIFT_NONE;
    case (it.kind)
      KIND_CMD:   model_command(it);
      KIND_TICK:  req = model_tick(it);
      KIND_ENC:   model_encoder(it);
      KIND_INDEX: model_index(it);
      KIND_TRIM:  model_trim();
      default: ;  // unused codes change nothing
    endcase
    res.lift_request = req;
    res.brake_on     = m_brake;
    res.turn_left    = m_left;
    res.motor_duty   = m_duty;
    res.disk_status  = m_status;
    res.busy_res     = m_busy;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting and checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [6:0] got, logic [6:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Compare every result transaction with the oldest outstanding prediction.
  always @(posedge clk) begin
    cpc_result_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        want = pending_outputs.pop_front();
        check_field("lift_request", out_chan.lift_request, want.lift_request);
        check_field("brake_on",     out_chan.brake_on,     want.brake_on);
        check_field("turn_left",    out_chan.turn_left,    want.turn_left);
        check_field("motor_duty",   out_chan.motor_duty,   want.motor_duty);
        check_field("disk_status",  out_chan.disk_status,  want.disk_status);
        check_field("busy_res",     out_chan.busy_res,     want.busy_res);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idling and back-pressure
  // --------------------------------------------------------------------------
  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drop result ready for random stretches; change only on the falling edge.
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold--;
      out_chan.ready = 1'b0;
    end else begin
      ready_hold = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
      out_chan.ready = (ready_hold == 0);
    end
  end

  // End the run when no channel has moved a transaction for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready) || rst_n !== 1'b1)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------
  // Present one event; valid stays high after acceptance until the next
  // falling edge, where it is either reloaded or lowered for a gap.
  task automatic send_item(cpc_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       = 1'b1;
    in_chan.kind        = it.kind;
    in_chan.target_slot = it.target_slot;
    in_chan.label_valid = it.label_valid;
    in_chan.label_code  = it.label_code;
    in_chan.lift_up     = it.lift_up;
    in_chan.lift_busy   = it.lift_busy;
    in_chan.lift_fault  = it.lift_fault;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pending_outputs.push_back(carousel_step(it));
    if (it.kind <= KIND_TRIM) useful_items++;
  endtask

  // Lower valid and wait until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the pipeline drained.
  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.addr  = idx;
    cfg_chan.data  = data;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    model_write_reg(idx, data);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Event builders
  // --------------------------------------------------------------------------
  function automatic cpc_item_t rand_item(logic [2:0] kind);
    cpc_item_t it;
    it.kind        = kind;
    it.target_slot = 5'($urandom);
    it.label_valid = 1'($urandom);
    it.label_code  = 4'($urandom);
    it.lift_up     = 1'($urandom);
    it.lift_busy   = 1'($urandom);
    it.lift_fault  = 1'($urandom);
    return it;
  endfunction

  // A tick whose lift inputs usually read settled.
  function automatic cpc_item_t lift_tick();
    cpc_item_t it;
    it = rand_item(KIND_TICK);
    if ($urandom_range(0, 4) != 0) begin
      it.lift_busy = 1'b0;
      it.lift_fault = 1'b0;
    end
    return it;
  endfunction

  function automatic cpc_item_t move_command(logic [3:0] goal, logic [3:0] from_slot);
    cpc_item_t it;
    it = rand_item(KIND_CMD);
    it.target_slot = {1'b0, goal};
    it.label_valid = 1'b1;
    it.label_code  = mirror_slot(from_slot);
    return it;
  endfunction

  task automatic tick_until_idle(int max_ticks);
    int n;
    n = 0;
    while (m_busy && n < max_ticks) begin
      send_item(lift_tick());
      n++;
    end
  endtask

  // Command a move and tick it through lift-up and start delay into rotation.
  // The label seen on the direction-choosing tick is given separately.
  task automatic start_move(logic [3:0] goal, logic [3:0] from_slot,
                            logic check_lv, logic [3:0] check_slot);
    cpc_item_t it;
    int        n;
    send_item(move_command(goal, from_slot));
    n = 0;
    while (m_busy && m_step != SEQ_ROT && n < 600) begin
      if ($urandom_range(0, 9) == 0) begin
        it = rand_item(KIND_TRIM);
      end else begin
        it = lift_tick();
        if (m_step == SEQ_CHECK) begin
          it.label_valid = check_lv;
          it.label_code  = mirror_slot(check_slot);
        end
      end
      send_item(it);
      n++;
    end
  endtask

  // Push encoder edges past the minimum count, with noise mixed in.
  task automatic spin_past_min_edges();
    cpc_item_t it;
    int        n;
    int        r;
    n = 0;
    while (m_step == SEQ_ROT && m_edges <= MIN_EDGES && n < 6000) begin
      r = $urandom_range(0, 99);
      if (r < 2)      it = lift_tick();
      else if (r < 7) it = rand_item(KIND_TRIM);
      else if (r < 9) it = rand_item(KIND_INDEX);
      else            it = rand_item(KIND_ENC);
      send_item(it);
      n++;
    end
  endtask

  // Index edge carrying a label other than the goal.
  function automatic cpc_item_t wrong_index();
    cpc_item_t it;
    it = rand_item(KIND_INDEX);
    it.label_valid = 1'b1;
    it.label_code  = mirror_slot(m_goal) ^ 4'($urandom_range(1, 15));
    return it;
  endfunction

  task automatic run_full_move(logic [3:0] goal, logic [3:0] from_slot,
                               logic check_lv, logic [3:0] check_slot);
    cpc_item_t it;
    int        n;
    start_move(goal, from_slot, check_lv, check_slot);
    spin_past_min_edges();
    // pass a few other slots, then the goal label arms the stop
    repeat ($urandom_range(0, 3)) send_item(wrong_index());
    it = rand_item(KIND_INDEX);
    it.label_valid = 1'b1;
    it.label_code  = mirror_slot(m_goal);
    send_item(it);
    n = 0;
    while (m_stop_pend && n < 70000) begin
      send_item(rand_item(($urandom_range(0, 19) == 0) ? KIND_TRIM : KIND_ENC));
      n++;
    end
    // down delay, lift down and release
    tick_until_idle(1000);
  endtask

  function automatic logic [15:0] pick_word(logic [15:0] cap);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom);
    return 16'($urandom_range(0, cap));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_brake_and_commands();
    cpc_item_t it;
    drain_results();
    write_reg(REG_DUTY_FAST, 16'hFFFF);       // clamps to full duty
    it = rand_item(KIND_CMD);
    it.target_slot = BRAKE_TOGGLE;
    it.lift_up = 1'b1;
    send_item(it);                            // brake on, duty off
    send_item(it);                            // brake off, fast duty
    it.lift_up = 1'b0;
    send_item(it);                            // lift down: not a toggle, ignored
    it.target_slot = 5'd31;
    it.lift_up = 1'b1;
    send_item(it);                            // beyond the last slot: ignored
    it = move_command(4'd7, 4'd3);
    it.label_valid = 1'b0;
    send_item(it);                            // no label: stays ready
    send_item(move_command(4'd7, 4'd7));      // already at the goal
    for (int k = KIND_TRIM + 1; k < 8; k++) send_item(rand_item(3'(k)));
    send_item(rand_item(KIND_TRIM));
    send_item(rand_item(KIND_TRIM));
    send_item(rand_item(KIND_ENC));
    send_item(rand_item(KIND_INDEX));
  endtask

  task automatic test_lift_timeout();
    cpc_item_t it;
    drain_results();
    write_reg(REG_TIMEOUT, 16'h0000);
    write_reg(REG_DUTY_SLOW, 16'h0080);       // low bits zero: duty off
    send_item(move_command(4'd0, 4'd15));
    it = lift_tick();
    it.lift_up = 1'b0;
    send_item(it);                            // asks for lift up
    send_item(it);                            // no time left: error
    send_item(it);                            // no index seen: disk absent
    drain_results();
    write_reg(REG_TIMEOUT, 16'd3);
    send_item(move_command(4'd15, 4'd0));
    repeat (6) begin
      it = rand_item(KIND_TICK);
      it.lift_busy = 1'b1;
      send_item(it);                          // lift never settles
      send_item(move_command(4'd4, 4'd9));    // ignored while busy
    end
  endtask

  task automatic test_presence_window();
    drain_results();
    write_reg(REG_TIMEOUT, 16'd400);
    write_reg(REG_PRESENCE, 16'd5);
    start_move(4'd11, 4'd1, 1'b1, 4'd1);
    tick_until_idle(500);
    drain_results();
    write_reg(REG_PRESENCE, 16'd0);
    start_move(4'd2, 4'd8, 1'b1, 4'd8);
    tick_until_idle(500);
    drain_results();
    // window longer than the whole timeout: only the timeout can end it
    write_reg(REG_TIMEOUT, 16'd300);
    write_reg(REG_PRESENCE, 16'hFFFF);
    start_move(4'd5, 4'd6, 1'b1, 4'd6);
    tick_until_idle(500);
  endtask

  // One move all the way to the braking stop, from a random start and goal.
  task automatic test_full_moves();
    logic [3:0] goal;
    logic [3:0] from_slot;
    drain_results();
    write_reg(REG_DUTY_FAST, 16'd60);
    write_reg(REG_DUTY_SLOW, 16'd30);
    write_reg(REG_TIMEOUT, 16'd5000);
    write_reg(REG_PRESENCE, 16'd1000);
    write_reg(REG_STOP_LEFT, 16'($urandom_range(0, 30)));
    write_reg(REG_STOP_RIGHT, 16'($urandom_range(0, 30)));
    write_reg(REG_TARGET_FAR, 16'($urandom_range(0, 300)));
    write_reg(REG_TARGET_NEAR, 16'($urandom_range(0, 300)));
    goal = 4'($urandom);
    from_slot = goal + 4'($urandom_range(1, 15));
    run_full_move(goal, from_slot, 1'b1, from_slot);
  endtask

  task automatic test_random_traffic();
    cpc_item_t  it;
    int         stop_at;
    int         r;
    logic [3:0] goal;
    logic [3:0] from_slot;
    stop_at = useful_items + 500;
    while (useful_items < stop_at) begin
      drain_results();
      idle_on = ($urandom_range(0, 3) != 0);
      write_reg(REG_DUTY_FAST, 16'($urandom));
      write_reg(REG_DUTY_SLOW, pick_word(16'd127));
      r = $urandom_range(0, 7);
      write_reg(REG_TIMEOUT, (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                             16'($urandom_range(1, 400)));
      write_reg(REG_PRESENCE, pick_word(16'd400));
      write_reg(REG_STOP_LEFT, pick_word(16'd30));
      write_reg(REG_STOP_RIGHT, pick_word(16'd30));
      write_reg(REG_TARGET_FAR, pick_word(16'd300));
      write_reg(REG_TARGET_NEAR, pick_word(16'd300));
      // most episodes open with a well-formed move command
      if ($urandom_range(0, 3) != 0 && !m_busy) begin
        goal = 4'($urandom);
        from_slot = ($urandom_range(0, 7) == 0) ? goal : 4'($urandom);
        start_move(goal, from_slot, ($urandom_range(0, 5) != 0), 4'($urandom));
      end
      repeat ($urandom_range(20, 200)) begin
        r = $urandom_range(0, 99);
        if (r < 45)      it = lift_tick();
        else if (r < 65) it = rand_item(KIND_ENC);
        else if (r < 75) begin
          it = rand_item(KIND_INDEX);
          if (r < 70) it.label_code = mirror_slot(m_goal);
        end
        else if (r < 85) it = rand_item(KIND_TRIM);
        else if (r < 95) it = rand_item(KIND_CMD);
        else             it = rand_item(3'($urandom_range(KIND_TRIM + 1, 7)));
        send_item(it);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.kind = '0;
    in_chan.target_slot = '0;
    in_chan.label_valid = 1'b0;
    in_chan.label_code = '0;
    in_chan.lift_up = 1'b0;
    in_chan.lift_busy = 1'b0;
    in_chan.lift_fault = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.addr = '0;
    cfg_chan.data = '0;
    model_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_brake_and_commands();
    test_lift_timeout();
    test_presence_window();
    test_full_moves();
    test_random_traffic();

    drain_results();
    if (pending_outputs.size() != 0) report_mismatch("results still outstanding at end");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cpc_pkg.sv
rtl/cpc_in_if.sv
rtl/cpc_out_if.sv
rtl/cpc_cfg_if.sv
rtl/cpc_cfg_regs.sv
rtl/cpc_seq.sv
rtl/carousel_position_controller.sv
tb/carousel_position_controller_tb.sv
